// ===== src/id_allocator_with_quarantine_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the id allocator core
// Shared helpers for concurrent checks, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ID_ALLOCATOR_WITH_QUARANTINE_CORE_ASSERT_SVH
`define ID_ALLOCATOR_WITH_QUARANTINE_CORE_ASSERT_SVH

// condition holds at every edge
`define IDQ_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define IDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/idq_pkg.sv =====
// ----------------------------------------------------------------------------
// idq_pkg
// Types and codes shared by the id allocator controller and datapath
// ----------------------------------------------------------------------------
package idq_pkg;

	// request kinds
	localparam logic [1:0] MODE_ALLOC   = 2'd0;
	localparam logic [1:0] MODE_RELEASE = 2'd1;
	localparam logic [1:0] MODE_LOCK    = 2'd2;
	localparam logic [1:0] MODE_DRAIN   = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_REL_UNTAKEN = 2'd1;
	localparam logic [1:0] ST_ALL_USED    = 2'd2;
	localparam logic [1:0] ST_LOCK_TAKEN  = 2'd3;

	// search passes
	localparam logic [1:0] PASS_CURSOR = 2'd1;
	localparam logic [1:0] PASS_LOW    = 2'd2;
	localparam logic [1:0] PASS_HIGH   = 2'd3;

	// register indexes
	localparam logic REG_WRAP_AT = 1'b0;
	localparam logic REG_DELAY   = 1'b1;

	typedef struct packed {
		logic       clr_write;
		logic       in_load;
		logic       fifo_read;
		logic       drain_read;
		logic       drain_free;
		logic       pass_start;
		logic [1:0] pass_sel;
		logic       scan_read;
		logic       scan_next;
		logic       grant;
		logic       id_read;
		logic       rel_free;
		logic       rel_quar;
		logic       lock_set;
		logic       set_status;
		logic [1:0] status_code;
		logic       out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic       clr_last;
		logic       fifo_nonempty;
		logic       head_due;
		logic       found;
		logic       row_last;
		logic [1:0] pass;
		logic       cursor_lt_w;
		logic       high_nonempty;
		logic       rel_ok;
		logic       lock_ok;
		logic       delay_zero;
		logic [1:0] mode;
		logic       out_free;
	} dp_sts_t;

endpackage

// ===== src/idq_ram.sv =====
// ----------------------------------------------------------------------------
// idq_ram
// Generic single write, single read RAM with registered read data
// ----------------------------------------------------------------------------
module idq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
	end

	// registered read, holds while idle
	always_ff @(posedge clk) begin
		if (re) rdata <= mem_q[raddr];
	end

endmodule

// ===== src/idq_ctrl.sv =====
// ----------------------------------------------------------------------------
// idq_ctrl
// Sequencer: clear sweep, quarantine drain, search passes, release and lock checks, result hand-off
// ----------------------------------------------------------------------------
`include "id_allocator_with_quarantine_core_assert.svh"

module idq_ctrl
	import idq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_acc,
	output logic    in_rdy,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [9:0] {
		S_CLR  = 10'b0000000001,
		S_IDLE = 10'b0000000010,
		S_DRD  = 10'b0000000100,
		S_DCHK = 10'b0000001000,
		S_DMAP = 10'b0000010000,
		S_OP   = 10'b0000100000,
		S_SRD  = 10'b0001000000,
		S_SCHK = 10'b0010000000,
		S_ICHK = 10'b0100000000,
		S_FIN  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	assign in_rdy = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLR: begin
				cmd.clr_write = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_acc) begin
					cmd.in_load = 1'b1;
					state_d     = S_DRD;
				end
			end
			S_DRD: begin
				if (sts.fifo_nonempty) begin
					cmd.fifo_read = 1'b1;
					state_d       = S_DCHK;
				end else begin
					state_d = S_OP;
				end
			end
			S_DCHK: begin
				if (sts.head_due) begin
					cmd.drain_read = 1'b1;
					state_d        = S_DMAP;
				end else begin
					state_d = S_OP;
				end
			end
			S_DMAP: begin
				cmd.drain_free = 1'b1;
				state_d        = S_DRD;
			end
			S_OP: begin
				case (sts.mode)
					MODE_ALLOC: begin
						cmd.pass_start = 1'b1;
						cmd.pass_sel   = sts.cursor_lt_w ? PASS_CURSOR : PASS_LOW;
						state_d        = S_SRD;
					end
					MODE_RELEASE, MODE_LOCK: begin
						cmd.id_read = 1'b1;
						state_d     = S_ICHK;
					end
					default: state_d = S_FIN;
				endcase
			end
			S_SRD: begin
				cmd.scan_read = 1'b1;
				state_d       = S_SCHK;
			end
			S_SCHK: begin
				if (sts.found) begin
					cmd.grant = 1'b1;
					state_d   = S_FIN;
				end else if (!sts.row_last) begin
					cmd.scan_next = 1'b1;
					state_d       = S_SRD;
				end else if (sts.pass == PASS_CURSOR) begin
					cmd.pass_start = 1'b1;
					cmd.pass_sel   = PASS_LOW;
					state_d        = S_SRD;
				end else if (sts.pass == PASS_LOW && sts.high_nonempty) begin
					cmd.pass_start = 1'b1;
					cmd.pass_sel   = PASS_HIGH;
					state_d        = S_SRD;
				end else begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_ALL_USED;
					state_d         = S_FIN;
				end
			end
			S_ICHK: begin
				if (sts.mode == MODE_RELEASE) begin
					if (!sts.rel_ok) begin
						cmd.set_status  = 1'b1;
						cmd.status_code = ST_REL_UNTAKEN;
					end else if (sts.delay_zero) begin
						cmd.rel_free = 1'b1;
					end else begin
						cmd.rel_quar = 1'b1;
					end
				end else if (sts.lock_ok) begin
					cmd.lock_set = 1'b1;
				end else begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_LOCK_TAKEN;
				end
				state_d = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_CLR;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLR;
		else         state_q <= state_d;
	end

	`IDQ_ASSERT_NEXT(a_load_to_drain, in_acc && in_rdy, state_q == S_DRD, "load did not start drain")
	`IDQ_ASSERT_NEXT(a_grant_to_fin, cmd.grant, state_q == S_FIN, "grant not followed by result")
	`IDQ_ASSERT(a_state_onehot, $onehot(state_q), "state register not one-hot")

endmodule

// ===== src/idq_dp.sv =====
// ----------------------------------------------------------------------------
// idq_dp
// Datapath: used/quarantine bitmap RAM, quarantine FIFO RAM, counters, result
// ----------------------------------------------------------------------------
`include "id_allocator_with_quarantine_core_assert.svh"

module idq_dp
	import idq_pkg::*;
#(
	parameter int NUM_IDS   = 1024,
	parameter int TIME_BITS = 32,
	localparam int ID_W     = $clog2(NUM_IDS),
	localparam int CNT_W    = $clog2(NUM_IDS + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_sts_t              sts,
	input  logic [1:0]           in_mode,
	input  logic [ID_W-1:0]      in_id,
	input  logic [TIME_BITS-1:0] in_time,
	input  logic [CNT_W-1:0]     wrap_at,
	input  logic [23:0]          release_delay,
	input  logic                 out_rdy,
	output logic                 out_vld,
	output logic [1:0]           out_status,
	output logic [ID_W-1:0]      out_granted,
	output logic                 out_wrapped,
	output logic [CNT_W-1:0]     out_freed,
	output logic [CNT_W-1:0]     out_used,
	output logic [CNT_W-1:0]     out_quar
);

	// bitmap rows: used bits low, quarantine bits high
	localparam int WORD_W = (NUM_IDS < 32) ? NUM_IDS : 32;
	localparam int BIT_W  = $clog2(WORD_W);
	localparam int ROWS   = NUM_IDS / WORD_W;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int FIFO_W = ID_W + TIME_BITS;
	localparam int SUM_W  = ((TIME_BITS > 24) ? TIME_BITS : 24) + 1;
	localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};

	function automatic logic [ROW_W-1:0] row_of(input logic [ID_W-1:0] v);
		row_of = ROW_W'(v >> BIT_W);
	endfunction

	logic [1:0]           mode_q;
	logic [ID_W-1:0]      id_q;
	logic [TIME_BITS-1:0] now_q;
	logic [1:0]           status_q;
	logic [ID_W-1:0]      granted_q;
	logic                 wrapped_q;
	logic [CNT_W-1:0]     freed_q;
	logic [ID_W-1:0]      head_q, tail_q;
	logic [CNT_W-1:0]     count_q, taken_q, cursor_q;
	logic [ROW_W-1:0]     clr_row_q, row_q;
	logic [ID_W-1:0]      from_q, last_q;
	logic [1:0]           pass_q;
	logic                 out_vld_q;

	logic                 map_we, map_re;
	logic [ROW_W-1:0]     map_waddr, map_raddr;
	logic [2*WORD_W-1:0]  map_wdata, map_rdata;
	logic [FIFO_W-1:0]    fifo_rdata;
	logic [ID_W-1:0]      fifo_id;
	logic [TIME_BITS-1:0] fifo_time;

	idq_ram #(.WIDTH(2 * WORD_W), .DEPTH(ROWS)) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.re    (map_re),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	// quarantine entry release time and saturation
	logic [SUM_W-1:0]     rel_sum;
	logic [TIME_BITS-1:0] rel_at;
	assign rel_sum = SUM_W'(now_q) + SUM_W'(release_delay);
	assign rel_at  = (rel_sum > SUM_W'({TIME_BITS{1'b1}})) ? {TIME_BITS{1'b1}}
	                                                       : TIME_BITS'(rel_sum);

	idq_ram #(.WIDTH(FIFO_W), .DEPTH(NUM_IDS)) u_fifo (
		.clk   (clk),
		.we    (cmd.rel_quar),
		.waddr (tail_q),
		.wdata ({rel_at, id_q}),
		.re    (cmd.fifo_read),
		.raddr (head_q),
		.rdata (fifo_rdata)
	);

	assign fifo_id   = fifo_rdata[ID_W-1:0];
	assign fifo_time = fifo_rdata[FIFO_W-1:ID_W];

	// clamped wrap point
	logic [CNT_W-1:0] wrap_w;
	always_comb begin
		if (wrap_at < CNT_W'(2))                 wrap_w = CNT_W'(2);
		else if (wrap_at > CNT_W'(NUM_IDS))      wrap_w = CNT_W'(NUM_IDS);
		else                                     wrap_w = wrap_at;
	end

	// pass range selection
	logic [CNT_W-1:0] pass_from, pass_to;
	always_comb begin
		case (cmd.pass_sel)
			PASS_CURSOR: begin pass_from = cursor_q;   pass_to = wrap_w;          end
			PASS_LOW:    begin pass_from = CNT_W'(1);  pass_to = wrap_w;          end
			default:     begin pass_from = wrap_w;     pass_to = CNT_W'(NUM_IDS); end
		endcase
	end

	// masked free bits of the scanned row and lowest free one
	logic [WORD_W-1:0] lo_mask, hi_mask, free_bits, low_hot;
	logic [BIT_W-1:0]  free_bit;
	always_comb begin
		lo_mask = (row_q == row_of(from_q)) ? (ONES << from_q[BIT_W-1:0]) : ONES;
		hi_mask = (row_q == row_of(last_q))
		        ? (ONES >> (BIT_W'(WORD_W - 1) - last_q[BIT_W-1:0])) : ONES;
		free_bits = ~map_rdata[WORD_W-1:0] & lo_mask & hi_mask;
		low_hot   = free_bits & (~free_bits + WORD_W'(1));
		free_bit  = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (low_hot[i]) free_bit = free_bit | BIT_W'(i);
		end
	end

	logic [ID_W-1:0] grant_id;
	assign grant_id = (ID_W'(row_q) << BIT_W) | ID_W'(free_bit);

	// bit positions for drain and id requests
	logic [BIT_W-1:0] id_bit, fifo_bit;
	assign id_bit   = id_q[BIT_W-1:0];
	assign fifo_bit = fifo_id[BIT_W-1:0];

	// bitmap port control
	always_comb begin
		map_re    = cmd.drain_read | cmd.scan_read | cmd.id_read;
		map_raddr = cmd.drain_read ? row_of(fifo_id) : (cmd.scan_read ? row_q : row_of(id_q));
		map_we    = cmd.clr_write | cmd.drain_free | cmd.grant | cmd.rel_free |
		            cmd.rel_quar | cmd.lock_set;
		map_waddr = row_of(id_q);
		map_wdata = map_rdata;
		if (cmd.clr_write) begin
			map_waddr = clr_row_q;
			map_wdata = (clr_row_q == '0) ? (2*WORD_W)'(1) : '0;
		end else if (cmd.drain_free) begin
			map_waddr = row_of(fifo_id);
			map_wdata[fifo_bit]          = 1'b0;
			map_wdata[WORD_W + fifo_bit] = 1'b0;
		end else if (cmd.grant) begin
			map_waddr = row_q;
			map_wdata[free_bit] = 1'b1;
		end else if (cmd.rel_free) begin
			map_wdata[id_bit] = 1'b0;
		end else if (cmd.rel_quar) begin
			map_wdata[WORD_W + id_bit] = 1'b1;
		end else if (cmd.lock_set) begin
			map_wdata[id_bit] = 1'b1;
		end
	end

	// status to controller
	always_comb begin
		sts.clr_last      = (clr_row_q == ROW_W'(ROWS - 1));
		sts.fifo_nonempty = (count_q != '0);
		sts.head_due      = (fifo_time <= now_q);
		sts.found         = |free_bits;
		sts.row_last      = (row_q == row_of(last_q));
		sts.pass          = pass_q;
		sts.cursor_lt_w   = (cursor_q < wrap_w);
		sts.high_nonempty = (wrap_w < CNT_W'(NUM_IDS));
		sts.rel_ok        = map_rdata[id_bit] & ~map_rdata[WORD_W + id_bit];
		sts.lock_ok       = ~map_rdata[id_bit];
		sts.delay_zero    = (release_delay == '0);
		sts.mode          = mode_q;
		sts.out_free      = ~out_vld_q | out_rdy;
	end

	// request and scan registers
	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			mode_q <= in_mode;
			id_q   <= in_id;
			now_q  <= in_time;
		end
		if (cmd.pass_start) begin
			from_q <= ID_W'(pass_from);
			last_q <= ID_W'(pass_to - CNT_W'(1));
			row_q  <= row_of(ID_W'(pass_from));
		end else if (cmd.scan_next) begin
			row_q <= row_q + ROW_W'(1);
		end
	end

	// control state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_row_q <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			taken_q   <= CNT_W'(1);
			cursor_q  <= CNT_W'(1);
			pass_q    <= PASS_CURSOR;
			status_q  <= ST_OK;
			granted_q <= '0;
			wrapped_q <= 1'b0;
			freed_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.clr_write) clr_row_q <= clr_row_q + ROW_W'(1);
			if (cmd.pass_start) pass_q <= cmd.pass_sel;
			if (cmd.in_load) begin
				status_q  <= ST_OK;
				granted_q <= '0;
				wrapped_q <= 1'b0;
				freed_q   <= '0;
			end
			if (cmd.set_status) status_q <= cmd.status_code;
			if (cmd.drain_free) begin
				head_q  <= head_q + ID_W'(1);
				count_q <= count_q - CNT_W'(1);
				freed_q <= freed_q + CNT_W'(1);
				if (taken_q != '0) taken_q <= taken_q - CNT_W'(1);
			end
			if (cmd.grant) begin
				granted_q <= grant_id;
				wrapped_q <= (pass_q == PASS_LOW);
				cursor_q  <= CNT_W'(grant_id) + CNT_W'(1);
				taken_q   <= taken_q + CNT_W'(1);
			end
			if (cmd.lock_set) taken_q <= taken_q + CNT_W'(1);
			if (cmd.rel_free && taken_q != '0) taken_q <= taken_q - CNT_W'(1);
			if (cmd.rel_quar) begin
				tail_q  <= tail_q + ID_W'(1);
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.out_load)  out_vld_q <= 1'b1;
			else if (out_rdy)  out_vld_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status  <= status_q;
			out_granted <= granted_q;
			out_wrapped <= wrapped_q;
			out_freed   <= freed_q;
			out_used    <= taken_q;
			out_quar    <= count_q;
		end
	end

	assign out_vld = out_vld_q;

	`IDQ_ASSERT(a_fifo_bound, count_q <= CNT_W'(NUM_IDS), "quarantine count above id space")
	`IDQ_ASSERT(a_quar_taken, count_q <= taken_q, "quarantined ids not counted as taken")
	`IDQ_ASSERT(a_cursor_range, cursor_q != '0 && cursor_q <= CNT_W'(NUM_IDS), "cursor out of range")

endmodule

// ===== src/id_allocator_with_quarantine_core.sv =====
// ----------------------------------------------------------------------------
// id_allocator_with_quarantine_core
// Next-fit bitmap id allocator with a timed release quarantine
// ----------------------------------------------------------------------------
// channel   dir  handshake            contents
// s_axis    in   tvalid/tready        tuser mode, tdata id and time_now
// m_axis    out  tvalid/tready        tuser status, tdata grant and counts
// apb       in   psel/penable/pwrite  wrap_at at 0x0, release_delay at 0x4
//
// An item first drains due quarantine entries, each a FIFO read, a due check,
// a bitmap read and a bit clear; allocate then scans bitmap rows, a read and
// a check per row (32 ids per row, up to three passes), while release and
// lock read and check the one row that holds the id.
// After reset a clearing pass writes every bitmap row before the first item
// is taken. A result waits in its output register while the next item is
// accepted; the result of that one waits for the slot to free.
// NUM_IDS is taken as a power of two.
// ----------------------------------------------------------------------------
module id_allocator_with_quarantine_core
	import idq_pkg::*;
#(
	parameter int NUM_IDS   = 1024,
	parameter int TIME_BITS = 32,
	localparam int ID_W     = $clog2(NUM_IDS),
	localparam int CNT_W    = $clog2(NUM_IDS + 1),
	localparam int IN_W     = ID_W + TIME_BITS,
	localparam int IN_TW    = ((IN_W + 7) / 8) * 8,
	localparam int OUT_W    = ID_W + 1 + 3 * CNT_W,
	localparam int OUT_TW   = ((OUT_W + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [IN_TW-1:0]  s_axis_tdata,  // id, time_now
	input  logic [1:0]        s_axis_tuser,  // mode
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_TW-1:0] m_axis_tdata,  // granted_id, wrapped, freed_count,
	                                         // used_count, quarantined_count
	output logic [1:0]        m_axis_tuser,  // status
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [CNT_W-1:0] wrap_at_q;
	logic [23:0]      delay_q;
	logic             cfg_wr;
	dp_cmd_t          cmd;
	dp_sts_t          sts;
	logic             in_rdy;

	logic [ID_W-1:0]  out_granted;
	logic             out_wrapped;
	logic [CNT_W-1:0] out_freed, out_used, out_quar;

	// register file
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_at_q <= CNT_W'(1024);
			delay_q   <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_WRAP_AT: wrap_at_q <= pwdata[CNT_W-1:0];
				default:     delay_q   <= pwdata[23:0];
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WRAP_AT: prdata = 32'(wrap_at_q);
			default:     prdata = {8'd0, delay_q};
		endcase
	end

	idq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.in_acc (s_axis_tvalid),
		.in_rdy (in_rdy),
		.sts    (sts),
		.cmd    (cmd)
	);

	assign s_axis_tready = in_rdy;

	idq_dp #(.NUM_IDS(NUM_IDS), .TIME_BITS(TIME_BITS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_mode       (s_axis_tuser),
		.in_id         (s_axis_tdata[ID_W-1:0]),
		.in_time       (s_axis_tdata[IN_W-1:ID_W]),
		.wrap_at       (wrap_at_q),
		.release_delay (delay_q),
		.out_rdy       (m_axis_tready),
		.out_vld       (m_axis_tvalid),
		.out_status    (m_axis_tuser),
		.out_granted   (out_granted),
		.out_wrapped   (out_wrapped),
		.out_freed     (out_freed),
		.out_used      (out_used),
		.out_quar      (out_quar)
	);

	// result packing
	assign m_axis_tdata = OUT_TW'({out_quar, out_used, out_freed, out_wrapped, out_granted});

endmodule
